[src/dass_pkg.sv]
// Package for the docking approach sequencer.
// Holds field widths, request and register codes, speed constants and the result type.
// No dependencies; every other file of the block uses it by scoped names.
package dass_pkg;

    // Field widths of the request, result and configuration channels.
    localparam int unsigned TypeW    = 2;
    localparam int unsigned CountW   = 2;
    localparam int unsigned PosW     = 14;
    localparam int unsigned VoltW    = 16;
    localparam int unsigned SpeedW   = 8;
    localparam int unsigned TurnW    = 7;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 13;
    localparam int unsigned ZErrW    = 10;
    localparam int unsigned DistW    = 13;
    localparam int unsigned FramesW  = 8;
    localparam int unsigned LatW     = 10;

    // Request kinds.
    typedef enum logic [TypeW-1:0] {
        REQ_FRAME   = 2'd0,
        REQ_VOLTAGE = 2'd1,
        REQ_REVERSE = 2'd2,
        REQ_NONE    = 2'd3
    } t_req_type;

    // Configuration register indexes.
    typedef enum logic [CfgIdxW-1:0] {
        CFG_Z_ERROR    = 3'd0,
        CFG_REVERSE    = 3'd1,
        CFG_CHECKPOINT = 3'd2,
        CFG_APPROACH   = 3'd3,
        CFG_LATERAL    = 3'd4
    } t_cfg_index;

    // Register values after reset.
    localparam logic [ZErrW-1:0]   ZErrorReset     = 10'd30;
    localparam logic [DistW-1:0]   ReverseReset    = 13'd650;
    localparam logic [FramesW-1:0] CheckpointReset = 8'd30;
    localparam logic [DistW-1:0]   ApproachReset   = 13'd300;
    localparam logic [LatW-1:0]    LateralReset    = 10'd50;

    // Docked hysteresis thresholds in millivolts.
    localparam logic [VoltW-1:0] DockedSetMv   = 16'd2600;
    localparam logic [VoltW-1:0] DockedClearMv = 16'd2500;

    // Speed and turn magnitudes; speeds are negated at the output, turn rates are not.
    localparam logic signed [SpeedW-1:0] SpeedFull    = 8'sd100;
    localparam logic signed [SpeedW-1:0] SpeedHalf    = 8'sd50;
    localparam logic signed [SpeedW-1:0] SpeedZero    = 8'sd0;
    localparam logic signed [SpeedW-1:0] TurnSearch   = 8'sd50;
    localparam logic signed [SpeedW-1:0] TurnReverse  = 8'sd30;

    // One result of a marker frame.
    typedef struct packed {
        logic signed [SpeedW-1:0] forward_speed;
        logic signed [SpeedW-1:0] side_speed;
        logic signed [TurnW-1:0]  turn_rate;
        logic                     status_valid;
        logic                     checkpoint_reached;
        logic                     moving_back;
    } t_result;

endpackage

[src/dass_in_if.sv]
// Request channel of the docking approach sequencer: valid, ready and the request fields.
// Depends on dass_pkg for the field widths.
interface dass_in_if;
    logic                             valid;
    logic                             ready;
    logic [dass_pkg::TypeW-1:0]       req_type;
    logic [dass_pkg::CountW-1:0]      marker_count;
    logic                             first_id;
    logic signed [dass_pkg::PosW-1:0] first_x_mm;
    logic signed [dass_pkg::PosW-1:0] first_z_mm;
    logic                             second_id;
    logic signed [dass_pkg::PosW-1:0] second_x_mm;
    logic signed [dass_pkg::PosW-1:0] second_z_mm;
    logic [dass_pkg::VoltW-1:0]       voltage_mv;
    logic                             reverse_flag;

    modport source (output valid, req_type, marker_count, first_id, first_x_mm, first_z_mm,
                    second_id, second_x_mm, second_z_mm, voltage_mv, reverse_flag,
                    input ready);
    modport sink (input valid, req_type, marker_count, first_id, first_x_mm, first_z_mm,
                  second_id, second_x_mm, second_z_mm, voltage_mv, reverse_flag,
                  output ready);
endinterface

[src/dass_out_if.sv]
// Result channel of the docking approach sequencer: valid, ready and the command fields.
// Depends on dass_pkg for the field widths.
interface dass_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [dass_pkg::SpeedW-1:0] forward_speed;
    logic signed [dass_pkg::SpeedW-1:0] side_speed;
    logic signed [dass_pkg::TurnW-1:0]  turn_rate;
    logic                               status_valid;
    logic                               checkpoint_reached;
    logic                               moving_back;

    modport source (output valid, forward_speed, side_speed, turn_rate, status_valid,
                    checkpoint_reached, moving_back, input ready);
    modport sink (input valid, forward_speed, side_speed, turn_rate, status_valid,
                  checkpoint_reached, moving_back, output ready);
endinterface

[src/dass_cfg_if.sv]
// Configuration write channel of the docking approach sequencer: valid, ready, index, data.
// Depends on dass_pkg for the index and data widths.
interface dass_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [dass_pkg::CfgIdxW-1:0]      index;
    logic [dass_pkg::CfgDataW-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[src/docking_approach_sequencer_unit.sv]
// Top level of the docking approach sequencer: request decode, steering decisions,
// state update and a registered result stage with a skid register.
// Depends on dass_pkg and the interfaces dass_in_if, dass_out_if and dass_cfg_if.
//
// Usage:
//   Requests arrive on i_in. A marker frame yields one velocity command with an
//   optional checkpoint status on o_out; a voltage sample or a reverse request only
//   updates the docked or reversing flag and yields nothing. Configuration writes
//   arrive on i_cfg, whose ready is always high, and take effect from the next request.
//   A command is registered in the result register, or in the skid register while
//   o_out is held. Throughput: one request per cycle while the skid register is empty.
//   The whole decision for a request, including the update of the docked, reversing
//   and checkpoint-count state, is one combinational pass ahead of the state and
//   result registers, so the next request sees the new state at once.
//   Stall: when o_out is held, one further command is kept in a skid register, and
//   i_in drops ready only while that register is occupied.
//   Reset: i_rst_n is synchronous and active low; it clears the flags, the checkpoint
//   count and the valid bits of both result registers, and loads every configuration
//   register with its default value.
module docking_approach_sequencer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dass_in_if.sink     i_in,
    dass_out_if.source  o_out,
    dass_cfg_if.sink    i_cfg
);

    // Configuration registers.
    logic [dass_pkg::ZErrW-1:0]   r_z_error;
    logic [dass_pkg::DistW-1:0]   r_reverse_dist;
    logic [dass_pkg::FramesW-1:0] r_cp_target;
    logic [dass_pkg::DistW-1:0]   r_approach_dist;
    logic [dass_pkg::LatW-1:0]    r_lateral_tol;

    // Sequencer state.
    logic                         r_docked, n_docked;
    logic                         r_reversing, n_reversing;
    logic [dass_pkg::FramesW-1:0] r_cp_frames, n_cp_frames;

    // Result and skid registers.
    dass_pkg::t_result r_out, r_skid, n_result;
    logic              r_out_v, r_skid_v;

    logic accept;
    logic new_v;
    logic out_free;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_skid_v;
    assign accept      = i_in.valid && i_in.ready;
    assign out_free    = !r_out_v || o_out.ready;
    assign new_v       = accept && (i_in.req_type == dass_pkg::REQ_FRAME);

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z_error       <= dass_pkg::ZErrorReset;
            r_reverse_dist  <= dass_pkg::ReverseReset;
            r_cp_target     <= dass_pkg::CheckpointReset;
            r_approach_dist <= dass_pkg::ApproachReset;
            r_lateral_tol   <= dass_pkg::LateralReset;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                dass_pkg::CFG_Z_ERROR:    r_z_error       <= i_cfg.data[dass_pkg::ZErrW-1:0];
                dass_pkg::CFG_REVERSE:    r_reverse_dist  <= i_cfg.data[dass_pkg::DistW-1:0];
                dass_pkg::CFG_CHECKPOINT: r_cp_target     <= i_cfg.data[dass_pkg::FramesW-1:0];
                dass_pkg::CFG_APPROACH:   r_approach_dist <= i_cfg.data[dass_pkg::DistW-1:0];
                dass_pkg::CFG_LATERAL:    r_lateral_tol   <= i_cfg.data[dass_pkg::LatW-1:0];
                default: ;
            endcase
        end
    end

    // Decision pass for one request: next state and the command of a marker frame.
    always_comb begin
        logic [dass_pkg::CountW-1:0]      cnt;
        logic signed [dass_pkg::PosW-1:0] m0x, m0z, m1x, m1z;
        logic signed [dass_pkg::PosW:0]   dz;
        logic [dass_pkg::PosW:0]          adz;
        logic signed [dass_pkg::PosW+1:0] xs, zs, abx, lat_s, nlat_s, app2, rev2;
        logic signed [dass_pkg::SpeedW-1:0] tv, sv, rv, ntv, nsv;
        logic heading, below, st_v, st_r, st_b;

        n_docked    = r_docked;
        n_reversing = r_reversing;
        n_cp_frames = r_cp_frames;

        cnt = (i_in.marker_count == 2'd3) ? 2'd0 : i_in.marker_count;

        // Per-marker offsets and depths; a missing marker reads as zero.
        m0x = '0; m0z = '0; m1x = '0; m1z = '0;
        if (cnt != 2'd0) begin
            if (i_in.first_id) begin
                m1x = i_in.first_x_mm; m1z = i_in.first_z_mm;
            end else begin
                m0x = i_in.first_x_mm; m0z = i_in.first_z_mm;
            end
        end
        if (cnt == 2'd2) begin
            if (i_in.second_id) begin
                m1x = i_in.second_x_mm; m1z = i_in.second_z_mm;
            end else begin
                m0x = i_in.second_x_mm; m0z = i_in.second_z_mm;
            end
        end

        dz     = {m0z[dass_pkg::PosW-1], m0z} - {m1z[dass_pkg::PosW-1], m1z};
        adz    = dz[dass_pkg::PosW] ? -dz : dz;
        xs     = {{2{m0x[dass_pkg::PosW-1]}}, m0x} + {{2{m1x[dass_pkg::PosW-1]}}, m1x};
        zs     = {{2{m0z[dass_pkg::PosW-1]}}, m0z} + {{2{m1z[dass_pkg::PosW-1]}}, m1z};
        abx    = xs[dass_pkg::PosW+1] ? -xs : xs;
        lat_s  = {6'd0, r_lateral_tol};
        nlat_s = -lat_s;
        app2   = {2'd0, r_approach_dist, 1'b0};
        rev2   = {2'd0, r_reverse_dist, 1'b0};

        tv = dass_pkg::SpeedZero; sv = dass_pkg::SpeedZero; rv = dass_pkg::SpeedZero;
        heading = 1'b0;
        st_v = 1'b0; st_r = 1'b0; st_b = 1'b0;
        below = r_cp_frames < r_cp_target;

        case (i_in.req_type)
            dass_pkg::REQ_VOLTAGE: begin
                if (accept) begin
                    if (i_in.voltage_mv > dass_pkg::DockedSetMv) begin
                        n_docked = 1'b1;
                    end else if (i_in.voltage_mv < dass_pkg::DockedClearMv) begin
                        n_docked = 1'b0;
                    end
                end
            end
            dass_pkg::REQ_REVERSE: begin
                if (accept && i_in.reverse_flag) begin
                    n_reversing = 1'b1;
                end
            end
            dass_pkg::REQ_FRAME: begin
                // Search turn while only one marker is visible.
                if (cnt == 2'd1 && below) begin
                    rv = i_in.first_id ? dass_pkg::TurnSearch : -dass_pkg::TurnSearch;
                end
                // Equalise the two depths.
                if (cnt == 2'd2 && below) begin
                    if (m0z > m1z && adz > {5'd0, r_z_error}) begin
                        sv = dass_pkg::SpeedFull; rv = -dass_pkg::TurnSearch;
                    end
                    if (m1z > m0z && adz > {5'd0, r_z_error}) begin
                        sv = -dass_pkg::SpeedFull; rv = dass_pkg::TurnSearch;
                    end
                    if (adz != '0 && adz < {5'd0, r_z_error}) begin
                        heading = 1'b1; rv = dass_pkg::SpeedZero;
                    end
                end
                // Approach, hold at the checkpoint, or back out when reversing.
                if (abx < lat_s && heading && below) begin
                    if (zs > app2 && !n_reversing) begin
                        tv = dass_pkg::SpeedFull;
                    end else begin
                        tv = dass_pkg::SpeedZero;
                        if (cnt == 2'd2 && !n_reversing) begin
                            n_cp_frames = r_cp_frames + 1'b1;
                            st_v = 1'b1; st_r = 1'b1; st_b = 1'b0;
                        end else if (n_reversing) begin
                            if (zs > rev2) begin
                                n_reversing = 1'b0;
                                n_cp_frames = '0;
                            end
                            tv = -dass_pkg::SpeedFull; rv = dass_pkg::TurnReverse;
                            sv = dass_pkg::SpeedZero;
                            st_v = 1'b1; st_r = 1'b0; st_b = 1'b0;
                        end
                    end
                end
                // Sideways correction on the summed offset.
                if (heading && (n_cp_frames < r_cp_target) && cnt == 2'd2 && !n_reversing) begin
                    if (xs > lat_s) sv = -dass_pkg::SpeedFull;
                    if (xs < nlat_s) sv = dass_pkg::SpeedFull;
                end
                // Checkpoint phase complete: back in, or back out when reversing.
                if (!(n_cp_frames < r_cp_target) && !r_docked) begin
                    if (!n_reversing) begin
                        tv = dass_pkg::SpeedHalf;
                        st_v = 1'b1; st_r = 1'b0; st_b = 1'b1;
                    end else begin
                        if (zs > rev2) begin
                            n_reversing = 1'b0;
                            n_cp_frames = '0;
                        end
                        tv = -dass_pkg::SpeedFull; rv = dass_pkg::TurnReverse;
                        sv = dass_pkg::SpeedZero;
                        st_v = 1'b1; st_r = 1'b0; st_b = 1'b0;
                    end
                end
                // Docked: stop everything.
                if (r_docked) begin
                    tv = dass_pkg::SpeedZero; sv = dass_pkg::SpeedZero;
                    rv = dass_pkg::SpeedZero;
                    n_cp_frames = '0;
                    n_reversing = 1'b0;
                    st_v = 1'b1; st_r = 1'b0; st_b = 1'b0;
                end
                if (!accept) begin
                    n_cp_frames = r_cp_frames;
                    n_reversing = r_reversing;
                end
            end
            default: ;
        endcase

        ntv = -tv;
        nsv = -sv;
        n_result.forward_speed      = ntv;
        n_result.side_speed         = nsv;
        n_result.turn_rate          = rv[dass_pkg::TurnW-1:0];
        n_result.status_valid       = st_v;
        n_result.checkpoint_reached = st_r;
        n_result.moving_back        = st_b;
    end

    // Sequencer state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_docked    <= 1'b0;
            r_reversing <= 1'b0;
            r_cp_frames <= '0;
        end else begin
            r_docked    <= n_docked;
            r_reversing <= n_reversing;
            r_cp_frames <= n_cp_frames;
        end
    end

    // Result register with a skid register behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (out_free) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= new_v;
            end
        end else if (new_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_v ? r_skid : n_result;
        end
        if (!out_free && new_v) begin
            r_skid <= n_result;
        end
    end

    assign o_out.valid              = r_out_v;
    assign o_out.forward_speed      = r_out.forward_speed;
    assign o_out.side_speed         = r_out.side_speed;
    assign o_out.turn_rate          = r_out.turn_rate;
    assign o_out.status_valid       = r_out.status_valid;
    assign o_out.checkpoint_reached = r_out.checkpoint_reached;
    assign o_out.moving_back        = r_out.moving_back;

    // The skid register only fills behind an occupied result register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid register holds a command while the result register is empty");

    // Status bits are only set alongside a status, and never both at once.
    a_status_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> ((r_out.status_valid || (!r_out.checkpoint_reached && !r_out.moving_back))
                     && !(r_out.checkpoint_reached && r_out.moving_back)))
        else $error("inconsistent checkpoint status bits");

    // A frame handled while docked clears the count and the reversing flag.
    a_docked_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (new_v && r_docked) |=> (r_cp_frames == '0 && !r_reversing))
        else $error("docked frame left checkpoint count or reversing set");

    // A request that is not a marker frame puts no command into an empty result stage.
    a_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !new_v && !r_out_v) |=> !r_out_v)
        else $error("non-frame request produced a command");

endmodule
